/* rtl/pbct_pkg.sv */
package pbct_pkg;

  // Geometry of the object: pieces per block and bytes per piece are powers of two.
  localparam int PIECES_PER_BLOCK = 256;
  localparam int PIECE_BYTES      = 1024;
  localparam int PIECE_SH         = 10;
  localparam int PIECE_W          = 8;
  localparam int BLOCK_SH         = PIECE_SH + PIECE_W;

  // Field widths.
  localparam int OFF_W  = 28;
  localparam int LEN_W  = 29;
  localparam int SIZE_W = 29;
  localparam int POS_W  = 30;
  localparam int BLK_W  = POS_W - BLOCK_SH;

  // Command kinds.
  localparam logic KIND_MARK  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_BEYOND  = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [OFF_W-1:0] byte_offset;
    logic [LEN_W-1:0] byte_length;
  } pbct_cmd_t;

  typedef struct packed {
    logic       ready_res;
    logic [1:0] status;
  } pbct_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_READ,
    S_MODIFY,
    S_FINISH
  } pbct_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic setup;
    logic rd;
    logic modify;
    logic finish;
  } pbct_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic skip;
    logic last;
  } pbct_sts_t;

endpackage

/* rtl/pbct_ctrl.sv */
module pbct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pbct_pkg::pbct_sts_t sts,
  output pbct_pkg::pbct_ctl_t ctl,
  output logic               busy
);

  pbct_pkg::pbct_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbct_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    case (state)
      pbct_pkg::S_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = pbct_pkg::S_IDLE;
        end
      end
      pbct_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = pbct_pkg::S_SETUP;
        end
      end
      pbct_pkg::S_SETUP: begin
        ctl.setup  = 1'b1;
        state_next = sts.skip ? pbct_pkg::S_FINISH : pbct_pkg::S_READ;
      end
      pbct_pkg::S_READ: begin
        ctl.rd     = 1'b1;
        state_next = pbct_pkg::S_MODIFY;
      end
      pbct_pkg::S_MODIFY: begin
        ctl.modify = 1'b1;
        if (sts.last) begin
          ctl.finish = 1'b1;
          state_next = pbct_pkg::S_IDLE;
        end else begin
          state_next = pbct_pkg::S_READ;
        end
      end
      pbct_pkg::S_FINISH: begin
        ctl.finish = 1'b1;
        state_next = pbct_pkg::S_IDLE;
      end
      default: begin
        state_next = pbct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/pbct_dp.sv */
module pbct_dp #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pbct_pkg::pbct_ctl_t              ctl,
  output pbct_pkg::pbct_sts_t              sts,
  input  pbct_pkg::pbct_cmd_t              cmd,
  input  logic                             cfg_valid,
  input  logic [pbct_pkg::SIZE_W-1:0]      cfg_data,
  output pbct_pkg::pbct_res_t              result,
  output logic                             done
);

  localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PPB = pbct_pkg::PIECES_PER_BLOCK;
  localparam int PW  = pbct_pkg::PIECE_W;
  localparam int BW  = pbct_pkg::BLK_W;
  localparam int BSH = pbct_pkg::BLOCK_SH;
  localparam int PSH = pbct_pkg::PIECE_SH;

  // Each row holds the piece bitmap of one block with its done flag on top.
  logic [PPB:0] mem [MAX_BLOCKS];
  logic [PPB:0] rd_q;

  logic [pbct_pkg::SIZE_W-1:0] object_size;
  pbct_pkg::pbct_cmd_t         cmd_q;
  logic [pbct_pkg::POS_W-1:0]  endm1_q;
  logic [BW-1:0]               last_blk_q;
  logic [BW-1:0]               stop_blk_q;
  logic [BW-1:0]               cur_blk;
  logic                        beyond_q;
  logic                        zero_q;
  logic                        ready_acc;
  logic [AW-1:0]               clr_addr;

  // Block count and last block geometry from the object size.
  logic [BW-1:0]              count_raw;
  logic [BW-1:0]              count;
  logic [BW-1:0]              size_last_blk;
  logic                       size_partial;
  logic [PW-1:0]              lim_last_m1;

  always_comb begin
    count_raw = {1'b0, object_size[pbct_pkg::SIZE_W-1:BSH]}
              + BW'(|object_size[BSH-1:0]);
    count = (32'(count_raw) > MAX_BLOCKS) ? BW'(MAX_BLOCKS) : count_raw;
    size_last_blk = BW'((object_size - 1'b1) >> BSH);
    size_partial  = |object_size[BSH-1:0];
    lim_last_m1   = object_size[BSH-1:PSH] - PW'(~|object_size[PSH-1:0]);
  end

  // Range bounds worked out while the controller is in setup.
  logic [pbct_pkg::POS_W-1:0] endm1;
  logic [BW-1:0]              first_blk;
  logic [BW-1:0]              last_blk;
  logic                       none_in;
  logic                       beyond;

  always_comb begin
    endm1 = pbct_pkg::POS_W'(cmd_q.byte_offset) + pbct_pkg::POS_W'(cmd_q.byte_length)
          - 1'b1;
    first_blk = BW'(cmd_q.byte_offset[pbct_pkg::OFF_W-1:BSH]);
    last_blk  = endm1[pbct_pkg::POS_W-1:BSH];
    none_in   = first_blk >= count;
    beyond    = last_blk >= count;
  end

  // Read-modify-write of one block row.
  logic [PW-1:0]  first_pc;
  logic [PW-1:0]  last_pc;
  logic [PW-1:0]  lim_m1;
  logic [PW-1:0]  last_c;
  logic [PPB-1:0] mark_mask;
  logic [PPB-1:0] valid_mask;
  logic [PPB-1:0] new_bits;
  logic           new_done;
  logic           ready_now;

  always_comb begin
    first_pc = (cur_blk == BW'(cmd_q.byte_offset[pbct_pkg::OFF_W-1:BSH]))
             ? cmd_q.byte_offset[BSH-1:PSH] : '0;
    last_pc  = (cur_blk == last_blk_q) ? endm1_q[BSH-1:PSH] : '1;
    lim_m1   = (size_partial && cur_blk == size_last_blk) ? lim_last_m1 : '1;
    last_c   = (last_pc > lim_m1) ? lim_m1 : last_pc;
    mark_mask  = ({PPB{1'b1}} << first_pc) & ({PPB{1'b1}} >> (~last_c));
    valid_mask = {PPB{1'b1}} >> (~lim_m1);
    new_bits   = rd_q[PPB-1:0] | mark_mask;
    new_done   = rd_q[PPB] | (&(new_bits | ~valid_mask));
    ready_now  = ready_acc &
                 ~(ctl.modify && cmd_q.kind == pbct_pkg::KIND_QUERY && !rd_q[PPB]);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      mem[clr_addr] <= '0;
    end else if (ctl.modify && cmd_q.kind == pbct_pkg::KIND_MARK) begin
      mem[AW'(cur_blk)] <= {new_done, new_bits};
    end
    if (ctl.rd) begin
      rd_q <= mem[AW'(cur_blk)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_size <= '0;
      clr_addr    <= '0;
      done        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        object_size <= cfg_data;
      end
      if (ctl.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
    end
    if (ctl.setup) begin
      endm1_q    <= endm1;
      last_blk_q <= last_blk;
      stop_blk_q <= beyond ? count - 1'b1 : last_blk;
      cur_blk    <= first_blk;
      beyond_q   <= beyond;
      zero_q     <= (cmd_q.byte_length == '0);
      ready_acc  <= 1'b1;
    end
    if (ctl.modify) begin
      cur_blk   <= cur_blk + 1'b1;
      ready_acc <= ready_now;
    end
    if (ctl.finish) begin
      result.ready_res <= (cmd_q.kind == pbct_pkg::KIND_QUERY) && !zero_q && !beyond_q
                          && ready_now;
      result.status    <= zero_q ? pbct_pkg::ST_ZERO
                        : (beyond_q ? pbct_pkg::ST_BEYOND : pbct_pkg::ST_OK);
    end
  end

  always_comb begin
    sts.clear_last = (32'(clr_addr) == MAX_BLOCKS - 1);
    sts.skip       = (cmd_q.byte_length == '0) || none_in;
    sts.last       = (cur_blk == stop_blk_q);
  end

endmodule

/* rtl/piece_bitmap_completion_tracker.sv */
// Piece bitmap completion tracker. The block keeps one bit per 1 KiB piece of
// every 256 KiB block of an object, plus a done flag per block, in one memory
// row per block. A mark command sets the piece bits its byte range covers,
// clipped to the pieces that lie inside the object, and a query command
// answers whether every block the range touches is done. A command is taken
// when start is high and busy is low; its single result appears on result
// for exactly one cycle with done high, and the receiver cannot stall it.
// After a command is accepted the block runs a setup step, then for each
// block of the range that lies inside the object one memory read step and
// one modify step, which writes the row back for a mark; busy stays high
// until the last such block is through, so commands do not overlap. A
// zero-length range, or one that lies wholly past the last block, goes from
// setup straight to a finish step. After reset the block runs a clearing
// pass over all MAX_BLOCKS rows, one row per cycle, with busy high.
// The object size register may be written at any time the block is idle and
// is taken on every transaction of the configuration channel; changing it
// keeps all piece bits and done flags.
module piece_bitmap_completion_tracker #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  pbct_pkg::pbct_cmd_t         cmd,
  output logic                        done,
  output pbct_pkg::pbct_res_t         result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pbct_pkg::SIZE_W-1:0] cfg_data
);

  pbct_pkg::pbct_ctl_t ctl;
  pbct_pkg::pbct_sts_t sts;

  // The size register is a plain flop, so a write is never held off.
  assign cfg_ready = 1'b1;

  pbct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  pbct_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .result    (result),
    .done      (done)
  );

endmodule
